// File: rtl/core/ppfa_pkg.sv
`timescale 1ns / 1ps
package ppfa_pkg;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OOM      = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   // csr register indexes
   localparam logic CSR_LOWEST_ADDRESS = 1'b0;
   localparam logic CSR_TOP_ADDRESS    = 1'b1;

   // request word
   typedef struct packed {
      logic        kind;
      logic [2:0]  cpu;
      logic [31:0] address;
   } req_type;

   // result word
   typedef struct packed {
      logic [31:0] page_address;
      logic [1:0]  status;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REM,
      ST_POP,
      ST_POPW
   } ppfa_state_type;

endpackage

// File: rtl/core/ppfa_link_ram.sv
`timescale 1ns / 1ps
module ppfa_link_ram #(
   parameter int DEPTH = 32768,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/ppfa_page_rem.sv
`timescale 1ns / 1ps
module ppfa_page_rem #(
   parameter int NUM_PAGES = 32768,
   parameter int QW        = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [QW-1:0]                quot,
   output logic                         done,
   output logic [$clog2(NUM_PAGES)-1:0] rem
);
   localparam int PW      = $clog2(NUM_PAGES);
   localparam bit IS_POW2 = (NUM_PAGES == (1 << PW));
   localparam int XW      = (QW > PW) ? QW : PW;

   generate
      if (IS_POW2) begin : g_mask
         logic [XW-1:0] quot_x;
         logic [PW-1:0] rem_ff;
         logic          done_ff;

         assign quot_x = XW'(quot);

         // page count is a power of two: remainder is the low bits
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else if (start) begin
               done_ff <= 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               rem_ff <= quot_x[PW-1:0];
            end
         end

         assign done = done_ff;
         assign rem  = rem_ff;
      end else begin : g_recip
         // shift and rounded-up reciprocal give an exact quotient for any QW-bit input
         localparam int         KSH   = QW + PW;
         localparam int         PRW   = KSH + QW;
         localparam logic [63:0] MAGIC =
            ((64'd1 << KSH) + 64'(NUM_PAGES) - 64'd1) / 64'(NUM_PAGES);

         logic           x_vld_ff, x_vld_in;
         logic           p_vld_ff, p_vld_in;
         logic           done_ff, done_in;
         logic [QW-1:0]  x_ff, x_in;
         logic [PRW-1:0] prod_ff, prod_in;
         logic [PW-1:0]  r_ff, r_in;
         logic [QW-1:0]  quo;
         logic [QW-1:0]  quo_n;
         logic [XW-1:0]  diff;

         // quotient by reciprocal multiply, then remainder by multiply and subtract
         always_comb begin
            x_vld_in = start;
            p_vld_in = x_vld_ff && !start;
            done_in  = !start && (done_ff || p_vld_ff);
            x_in     = start ? quot : x_ff;
            prod_in  = x_vld_ff ? (PRW'(x_ff) * PRW'(MAGIC)) : prod_ff;
            quo      = prod_ff[KSH +: QW];
            quo_n    = QW'(32'(quo) * 32'(NUM_PAGES));
            diff     = XW'(x_ff - quo_n);
            r_in     = p_vld_ff ? diff[PW-1:0] : r_ff;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               x_vld_ff <= 1'b0;
               p_vld_ff <= 1'b0;
               done_ff  <= 1'b0;
            end else begin
               x_vld_ff <= x_vld_in;
               p_vld_ff <= p_vld_in;
               done_ff  <= done_in;
            end
         end

         always_ff @(posedge clock) begin
            x_ff    <= x_in;
            prod_ff <= prod_in;
            r_ff    <= r_in;
         end

         assign done = done_ff;
         assign rem  = r_ff;
      end
   endgenerate
endmodule

// File: rtl/core/per_cpu_page_free_list_allocator_core.sv
`timescale 1ns / 1ps
// Per-CPU page free-list allocator. Each CPU owns a LIFO list of free pages;
// the list heads sit in flip-flops and the next links in a single-port-write,
// registered-read RAM of NUM_PAGES entries indexed by page number. A free
// (kind 1) checks alignment and the [lowest_address, top_address) window and
// pushes the page on the requesting CPU's list; an allocate (kind 0) pops the
// own list, or else the lowest-numbered CPU list that has a page, or reports
// out of memory. One request is handled at a time: an allocate steps through
// accept, head select with link read and head update; a rejected free through
// accept and address check; an accepted free through accept, address check
// and the page-number remainder, which is the masked low bits when NUM_PAGES
// is a power of two and a reciprocal-multiply remainder unit otherwise. A new
// request is taken while the previous result still waits on the rsp side; the
// next result then waits until that word is taken. The link RAM is not
// cleared after reset; a pop only follows links that a push wrote. PAGE_BYTES
// must be a power of two. CSR writes are always accepted and must only be
// issued while the block is idle.
module per_cpu_page_free_list_allocator_core #(
   parameter int NUM_CPUS   = 8,
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ppfa_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ppfa_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_data
);
   import ppfa_pkg::*;

   localparam int PW   = $clog2(NUM_PAGES);
   localparam int CW   = $clog2(NUM_CPUS);
   localparam int SH   = $clog2(PAGE_BYTES);
   localparam int QW   = 32 - SH;
   localparam int OFSW = (PW + SH > 32) ? (PW + SH) : 32;

   // csr registers
   logic [31:0] lowest_ff, top_ff;

   // list heads
   logic [NUM_CPUS-1:0] head_valid_ff;
   logic [PW-1:0]       head_index_ff [NUM_CPUS];
   logic                head_we;
   logic [CW-1:0]       head_wsel;
   logic                head_wvalid;
   logic [PW-1:0]       head_windex;

   // sequencer and request registers
   ppfa_state_type state_ff, state_in;
   req_type        req_ff, req_in;
   logic [CW-1:0]  cpu_ff, cpu_in;
   logic [CW-1:0]  sel_ff, sel_in;
   logic [4:0]     cpu_wrap;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    out_free;

   // link ram and remainder unit
   logic          link_we, link_re;
   logic [PW-1:0] link_waddr, link_raddr;
   logic [PW:0]   link_wdata, link_rdata;
   logic          rem_start, rem_done;
   logic [PW-1:0] rem_page;

   // datapath helpers
   logic [31:0]     base;
   logic [31:0]     offset;
   logic            bad_free;
   logic            any_valid;
   logic [CW-1:0]   pop_sel;
   logic [OFSW-1:0] page_ofs;

   assign csr_ready = 1'b1;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff <= 32'h8000_0000;
         top_ff    <= 32'h8800_0000;
      end else if (csr_valid) begin
         if (csr_index == CSR_LOWEST_ADDRESS) begin
            lowest_ff <= csr_data;
         end else begin
            top_ff <= csr_data;
         end
      end
   end

   // cpu number taken modulo the cpu count
   always_comb begin
      cpu_wrap = {2'b00, req_word.cpu};
      for (int k = 0; k < 4; k++) begin
         if (cpu_wrap >= 5'(NUM_CPUS)) begin
            cpu_wrap = cpu_wrap - 5'(NUM_CPUS);
         end
      end
   end

   // free address check and page number
   assign base     = lowest_ff & ~32'(PAGE_BYTES - 1);
   assign offset   = req_ff.address - base;
   assign bad_free = (req_ff.address[SH-1:0] != '0) || (req_ff.address < lowest_ff) ||
                     (req_ff.address >= top_ff);

   // pop source: own list, else lowest-numbered list with a page
   always_comb begin
      any_valid = 1'b0;
      pop_sel   = cpu_ff;
      if (head_valid_ff[cpu_ff]) begin
         any_valid = 1'b1;
      end else begin
         for (int i = NUM_CPUS - 1; i >= 0; i--) begin
            if (head_valid_ff[i]) begin
               any_valid = 1'b1;
               pop_sel   = CW'(i);
            end
         end
      end
   end

   // byte offset of the popped page
   assign page_ofs = OFSW'(head_index_ff[sel_ff]) << SH;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and control
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cpu_in       = cpu_ff;
      sel_in       = sel_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      head_we      = 1'b0;
      head_wsel    = cpu_ff;
      head_wvalid  = 1'b1;
      head_windex  = rem_page;
      link_we      = 1'b0;
      link_waddr   = rem_page;
      link_wdata   = {head_valid_ff[cpu_ff], head_index_ff[cpu_ff]};
      link_re      = 1'b0;
      link_raddr   = head_index_ff[pop_sel];
      rem_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_word;
               cpu_in   = cpu_wrap[CW-1:0];
               state_in = (req_word.kind == KIND_FREE) ? ST_CHECK : ST_POP;
            end
         end
         ST_CHECK: begin
            if (bad_free) begin
               if (out_free) begin
                  rsp_in       = '{page_address: 32'd0, status: STATUS_BAD_FREE};
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               rem_start = 1'b1;
               state_in  = ST_REM;
            end
         end
         ST_REM: begin
            if (rem_done && out_free) begin
               link_we      = 1'b1;
               head_we      = 1'b1;
               rsp_in       = '{page_address: 32'd0, status: STATUS_OK};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_POP: begin
            if (out_free) begin
               if (any_valid) begin
                  link_re  = 1'b1;
                  sel_in   = pop_sel;
                  state_in = ST_POPW;
               end else begin
                  rsp_in       = '{page_address: 32'd0, status: STATUS_OOM};
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_POPW: begin
            head_we      = 1'b1;
            head_wsel    = sel_ff;
            head_wvalid  = link_rdata[PW];
            head_windex  = link_rdata[PW-1:0];
            rsp_in       = '{page_address: base + page_ofs[31:0], status: STATUS_OK};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         head_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (head_we) begin
            head_valid_ff[head_wsel] <= head_wvalid;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      cpu_ff <= cpu_in;
      sel_ff <= sel_in;
      rsp_ff <= rsp_in;
      if (head_we) begin
         head_index_ff[head_wsel] <= head_windex;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // next-link store
   ppfa_link_ram #(
      .DEPTH (NUM_PAGES),
      .WIDTH (PW + 1)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // page number modulo the page count
   ppfa_page_rem #(
      .NUM_PAGES (NUM_PAGES),
      .QW        (QW)
   ) u_page_rem (
      .clock (clock),
      .reset (reset),
      .start (rem_start),
      .quot  (offset[31:SH]),
      .done  (rem_done),
      .rem   (rem_page)
   );

   // a link read is only issued when some list holds a page
   assert property (@(posedge clock) disable iff (reset)
      link_re |-> (|head_valid_ff))
      else $error("link read with all lists empty");

   // head update from the link ram comes in the cycle after the read
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POPW |-> $past(state_ff) == ST_POP && $past(link_re))
      else $error("pop update without a link read");

   // every pop produces a result word
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POPW |=> rsp_valid_ff)
      else $error("pop finished without a result");

   // remainder unit stays inside the page range
   assert property (@(posedge clock) disable iff (reset)
      rem_done |-> ({1'b0, rem_page} < (PW + 1)'(NUM_PAGES)))
      else $error("page number out of range");
endmodule
